/* rtl/sit_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the sorted insert table
// Table geometry, field widths, mode codes and the control/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package sit_pkg;

  // table geometry and field widths
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // controller -> datapath commands (one cycle each)
  typedef struct packed {
    logic load;        // capture a new item, clear results
    logic fetch;       // read entry at ptr, step ptr down
    logic shift;       // move fetched entry one slot up (or drop it)
    logic place_hole;  // store value above fetched entry (or drop it)
    logic place_zero;  // store value in slot zero
    logic rd_capture;  // fetched entry becomes read data
    logic count_inc;   // bump fill count unless full
    logic load_out;    // move results into the output register
  } sit_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic mode_read;   // held item is a read
    logic empty;       // table holds no entries
    logic idx_past;    // read index at or beyond fill count
    logic gt;          // fetched entry is greater than the value
    logic cur_zero;    // fetched entry sits in slot zero
  } sit_status_t;

endpackage

`default_nettype wire

/* rtl/sit_item_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_item_if: input item channel
// Valid/ready channel that carries one insert or read request.
// ----------------------------------------------------------------------------
interface sit_item_if
  import sit_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] value;
  logic        [IDX_W-1:0]  index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

`default_nettype wire

/* rtl/sit_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_result_if: result channel
// Valid/ready channel that carries one result per accepted item.
// ----------------------------------------------------------------------------
interface sit_result_if
  import sit_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [IDX_W-1:0]  position;
  logic        [CNT_W-1:0]  count_after;
  logic                     dropped;
  logic signed [DATA_W-1:0] dropped_value;
  logic signed [DATA_W-1:0] read_data;

  modport source (output valid, output position, output count_after, output dropped,
                  output dropped_value, output read_data, input ready);
  modport sink   (input valid, input position, input count_after, input dropped,
                  input dropped_value, input read_data, output ready);
endinterface

`default_nettype wire

/* rtl/sit_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_datapath: entry memory, walk pointer and result registers
// Holds the sorted entries in a one-write/one-read memory, the fill count,
// the item being worked on, the result fields and the output register.
// ----------------------------------------------------------------------------
module sit_datapath
  import sit_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sit_cmd_t                 cmd,
  output      sit_status_t              status,
  input  wire logic                     mode,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic        [IDX_W-1:0]  index,
  output      logic        [IDX_W-1:0]  position,
  output      logic        [CNT_W-1:0]  count_after,
  output      logic                     dropped,
  output      logic signed [DATA_W-1:0] dropped_value,
  output      logic signed [DATA_W-1:0] read_data
);

  // entry store; slots at or past count are never read
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // held item
  logic                     item_mode;
  logic signed [DATA_W-1:0] item_val;
  logic        [IDX_W-1:0]  item_idx;

  // walk pointer (next read) and index of the fetched entry
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] hole;
  logic             cur_top;

  // per-item results
  logic        [IDX_W-1:0]  res_position;
  logic                     res_dropped;
  logic signed [DATA_W-1:0] res_dvalue;
  logic signed [DATA_W-1:0] res_rdata;

  // memory write port
  logic                     wr_en;
  logic        [IDX_W-1:0]  wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign hole    = cur + 1'b1;
  assign cur_top = (cur == IDX_W'(DEPTH - 1));

  // status back to the controller
  assign status.mode_read = (item_mode == MODE_READ);
  assign status.empty     = (count == '0);
  assign status.idx_past  = (CNT_W'(item_idx) >= count);
  assign status.gt        = (rd_data > item_val);
  assign status.cur_zero  = (cur == '0);

  // write port select; a move or place past the top slot is a drop
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hole;
    wr_data = rd_data;
    if (cmd.shift && !cur_top) begin
      wr_en = 1'b1;
    end
    if (cmd.place_hole && !cur_top) begin
      wr_en   = 1'b1;
      wr_data = item_val;
    end
    if (cmd.place_zero) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = item_val;
    end
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.fetch) begin
      rd_data <= mem[ptr];
    end
  end

  // fill count
  always_comb begin
    count_next = count;
    if (cmd.count_inc && (count < CNT_W'(DEPTH))) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // item, pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode    <= mode;
      item_val     <= value;
      item_idx     <= index;
      ptr          <= (mode == MODE_READ) ? index : IDX_W'(count - 1'b1);
      res_position <= '0;
      res_dropped  <= 1'b0;
      res_dvalue   <= '0;
      res_rdata    <= '0;
    end
    if (cmd.fetch) begin
      cur <= ptr;
      ptr <= ptr - 1'b1;
    end
    if (cmd.shift && cur_top) begin
      res_dropped <= 1'b1;
      res_dvalue  <= rd_data;
    end
    if (cmd.place_hole) begin
      if (cur_top) begin
        res_dropped  <= 1'b1;
        res_dvalue   <= item_val;
        res_position <= IDX_W'(DEPTH - 1);
      end else begin
        res_position <= hole;
      end
    end
    if (cmd.place_zero) begin
      res_position <= '0;
    end
    if (cmd.rd_capture) begin
      res_rdata <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      position      <= res_position;
      count_after   <= count;
      dropped       <= res_dropped;
      dropped_value <= res_dvalue;
      read_data     <= res_rdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/sit_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_ctrl: sequencer for the sorted insert table
// Accepts one item at a time, walks the table downward from the top entry,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module sit_ctrl
  import sit_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  input  wire sit_status_t status,
  output      sit_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_PLACE,
    S_RDCAP,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // no transfer is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.mode_read) begin
          if (status.idx_past) begin
            state_next = S_FINISH;
          end else begin
            cmd.fetch  = 1'b1;
            state_next = S_RDCAP;
          end
        end else if (status.empty) begin
          state_next = S_PLACE;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_WALK;
        end
      end
      // one entry per cycle: move it up, or drop the value in above it
      S_WALK: begin
        if (status.gt) begin
          cmd.shift = 1'b1;
          if (status.cur_zero) begin
            state_next = S_PLACE;
          end else begin
            cmd.fetch = 1'b1;
          end
        end else begin
          cmd.place_hole = 1'b1;
          cmd.count_inc  = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place_zero = 1'b1;
        cmd.count_inc  = 1'b1;
        state_next     = S_FINISH;
      end
      S_RDCAP: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sorted_insert_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_table_unit: ascending table of signed 32-bit entries
// Inserts values in order with overflow drop of the largest, and reads
// entries by index. Sequencer plus datapath with an entry memory.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                            | flow
//   item    | in  | mode, value, index                                 | valid/ready
//   result  | out | position, count_after, dropped, dropped_value,     | valid/ready
//           |     | read_data                                          |
//
// An insert walks down from the top entry; each of the m entries greater
// than the new value is moved up (on a full table the top one is pushed
// out), then the value is placed. The walk reads one entry per cycle
// through the single memory read port. A read fetches and returns the
// indexed entry, or returns zero when the index is past the fill count.
// Reset (rst, synchronous) empties the table at once by clearing the count.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module sorted_insert_table_unit
  import sit_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  sit_item_if.sink   item,
  sit_result_if.source result
);

  sit_cmd_t    cmd;
  sit_status_t status;

  sit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sit_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (item.mode),
    .value         (item.value),
    .index         (item.index),
    .position      (result.position),
    .count_after   (result.count_after),
    .dropped       (result.dropped),
    .dropped_value (result.dropped_value),
    .read_data     (result.read_data)
  );

endmodule

`default_nettype wire

/* verif/sorted_insert_table_unit_checker.sv */
// ----------------------------------------------------------------------------
// sorted_insert_table_unit_checker: table predictor and result comparator
// Watches both channels of the sorted insert table. Every item transfer is
// run through a private copy of the table to predict its result; every
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_insert_table_unit_checker
  import sit_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sit_item_if       item,
  sit_result_if     result,
  output int        errors,
  output int        pending
);

  typedef struct {
    logic        [IDX_W-1:0]  position;
    logic        [CNT_W-1:0]  count_after;
    logic                     dropped;
    logic signed [DATA_W-1:0] dropped_value;
    logic signed [DATA_W-1:0] read_data;
  } table_result_t;

  // shadow copy of the sorted table
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_fill;

  table_result_t            table_results_q [$];

  assign pending = table_results_q.size();

  // apply one item to the shadow table and return the result it must give
  task automatic apply_table_item(input logic m, input logic signed [DATA_W-1:0] v,
                                  input logic [IDX_W-1:0] ix, output table_result_t r);
    int  slot;
    bit  found;
    r.position      = '0;
    r.dropped       = 1'b0;
    r.dropped_value = '0;
    r.read_data     = '0;
    if (m == MODE_READ) begin
      if (int'(ix) < shadow_fill) r.read_data = shadow_entries[ix];
    end else begin
      // first valid slot strictly greater than the value; ties go after
      slot  = shadow_fill;
      found = 1'b0;
      for (int i = 0; i < shadow_fill; i++) begin
        if (!found && shadow_entries[i] > v) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (shadow_fill >= DEPTH) begin
        r.dropped = 1'b1;
        if (slot >= DEPTH) begin
          // value is the largest: it falls off, table untouched
          r.dropped_value = v;
          r.position      = IDX_W'(DEPTH - 1);
        end else begin
          r.dropped_value = shadow_entries[DEPTH-1];
          for (int i = DEPTH - 1; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = v;
          r.position = IDX_W'(slot);
        end
      end else begin
        for (int i = shadow_fill; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[slot] = v;
        r.position  = IDX_W'(slot);
        shadow_fill = shadow_fill + 1;
      end
    end
    r.count_after = CNT_W'(shadow_fill);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    table_result_t exp_r;
    table_result_t new_r;
    if (rst) begin
      shadow_fill = 0;
      for (int i = 0; i < DEPTH; i++) shadow_entries[i] = '0;
      table_results_q.delete();
    end else begin
      // results first: a result never belongs to the item taken at this edge
      if (result.valid && result.ready) begin
        if (table_results_q.size() == 0) begin
          $error("result transfer with no outstanding item");
          errors++;
        end else begin
          exp_r = table_results_q.pop_front();
          compare_field("position", exp_r.position, result.position);
          compare_field("count_after", exp_r.count_after, result.count_after);
          compare_field("dropped", exp_r.dropped, result.dropped);
          compare_field("dropped_value", exp_r.dropped_value, result.dropped_value);
          compare_field("read_data", exp_r.read_data, result.read_data);
        end
      end
      if (item.valid && item.ready) begin
        apply_table_item(item.mode, item.value, item.index, new_r);
        table_results_q.push_back(new_r);
      end
    end
  end

endmodule

/* verif/sorted_insert_table_unit_tb.sv */
// ----------------------------------------------------------------------------
// sorted_insert_table_unit_tb: top level bench for the sorted insert table
// Drives a directed opening (empty reads, extremes, ties, fill to full and
// overflow drops) and then a long mix of random inserts and reads, with
// random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module sorted_insert_table_unit_tb;
  import sit_pkg::*;

  localparam int RANDOM_ITEMS = 825;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  int   err_count;
  int   pending_count;
  int   items_sent;
  int   cycle_count;
  bit   hold_done;

  sit_item_if   item_ch ();
  sit_result_if result_ch ();

  sorted_insert_table_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  sorted_insert_table_unit_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (err_count),
    .pending (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_insert_table_unit_tb: errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random value: full range, a narrow band for ties, or an extreme
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return int'($urandom_range(0, 40)) - 20;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // one item transfer, entered and left at a falling edge
  task automatic send_item(input logic m, input logic signed [DATA_W-1:0] v,
                           input logic [IDX_W-1:0] ix);
    int g;
    item_ch.valid <= 1'b1;
    item_ch.mode  <= m;
    item_ch.value <= v;
    item_ch.index <= ix;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    @(negedge clk);
    g = pick_gap();
    if (g != 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // result side: random ready, one long hold-off once traffic is flowing
  initial begin
    int g;
    result_ch.ready = 1'b0;
    hold_done       = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      result_ch.ready <= 1'b1;
      @(negedge clk);
      g = pick_gap();
      if (g != 0) begin
        result_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // item side: reset, directed opening, random traffic, drain and verdict
  initial begin
    items_sent    = 0;
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.mode  = MODE_INSERT;
    item_ch.value = '0;
    item_ch.index = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reads of an empty table
    send_item(MODE_READ, 32'sd77, 4'd0);
    send_item(MODE_READ, -32'sd1, 4'd15);
    // zero as an ordinary value, extremes, ties, negative
    send_item(MODE_INSERT, 32'sd0, 4'd15);
    send_item(MODE_INSERT, 32'sh8000_0000, 4'd0);
    send_item(MODE_INSERT, 32'sh7FFF_FFFF, 4'd0);
    send_item(MODE_INSERT, 32'sd5, 4'd0);
    send_item(MODE_INSERT, 32'sd5, 4'd0);
    send_item(MODE_INSERT, -32'sd1, 4'd0);
    // a stored entry, then reads at and past the count
    send_item(MODE_READ, 32'sd0, 4'd3);
    send_item(MODE_READ, 32'sd0, 4'd6);
    send_item(MODE_READ, 32'sd0, 4'd15);
    // fill the table
    for (int i = 0; i < 10; i++) send_item(MODE_INSERT, pick_value(), 4'($urandom));
    // full table: largest value falls off itself, smallest pushes out the top
    send_item(MODE_INSERT, 32'sh7FFF_FFFF, 4'd0);
    send_item(MODE_INSERT, 32'sh8000_0000, 4'd0);
    send_item(MODE_READ, 32'sd0, 4'd15);
    send_item(MODE_READ, 32'sd0, 4'd0);

    // random mix of inserts and reads
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 45)
        send_item(MODE_READ, $urandom, 4'($urandom_range(0, 15)));
      else
        send_item(MODE_INSERT, pick_value(), 4'($urandom));
    end
    item_ch.valid <= 1'b0;

    // drain
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("sorted_insert_table_unit_tb: clean");
    end else begin
      $display("sorted_insert_table_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sit_pkg.sv
rtl/sit_item_if.sv
rtl/sit_result_if.sv
rtl/sit_datapath.sv
rtl/sit_ctrl.sv
rtl/sorted_insert_table_unit.sv
verif/sorted_insert_table_unit_checker.sv
verif/sorted_insert_table_unit_tb.sv
